// ===== design/trvg_pkg.sv =====
// Shared types, constants and tables of the tube ring vertex generator.
package trvg_pkg;

	localparam int CORDIC_STEPS = 24;
	localparam int SQRT_STEPS   = 32;
	localparam int DIV_STEPS    = 15;

	localparam logic signed [33:0] CORDIC_GAIN = 34'sd652032874;
	localparam logic signed [33:0] ONE_Q30     = 34'sd1073741824;

	// arctangent of 2^-i in units of 2^-32 turn
	localparam logic [31:0] ATAN_TURNS [CORDIC_STEPS] = '{
		32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756,
		32'd42667331,  32'd21354465,  32'd10679838,  32'd5340245,
		32'd2670163,   32'd1335087,   32'd667544,    32'd333772,
		32'd166886,    32'd83443,     32'd41722,     32'd20861,
		32'd10430,     32'd5215,      32'd2608,      32'd1304,
		32'd652,       32'd326,       32'd163,       32'd81
	};

	typedef struct packed {
		logic [2:0][31:0] m0;
		logic [2:0][31:0] m2;
		logic [2:0][31:0] m3;
		logic [30:0]      radius;
		logic [15:0]      tex_v;
	} ring_t;

	typedef struct packed {
		ring_t       ring;
		logic [15:0] tex_u;
		logic        last;
	} vinfo_t;

	typedef struct packed {
		logic signed [33:0] x;
		logic signed [33:0] y;
		logic signed [33:0] z;
		logic               neg;
		vinfo_t             info;
	} cordic_t;

	typedef struct packed {
		logic [2:0][31:0] pos;
		logic [2:0][29:0] nmag;
		logic [2:0]       nneg;
		logic             nzero;
		logic [15:0]      tex_u;
		logic [15:0]      tex_v;
		logic             last;
	} tail_t;

	typedef struct packed {
		logic [63:0] v;
		logic [63:0] res;
		tail_t       tail;
	} sqrt_t;

	typedef struct packed {
		logic [2:0][45:0] rem;
		logic [2:0][14:0] q;
		logic [31:0]      len;
		tail_t            tail;
	} dvd_t;

	typedef struct packed {
		logic div_busy;
		logic active;
	} seq_stat_t;

endpackage

// ===== design/trvg_if.sv =====
// Ring input and vertex output channel interfaces.
interface trvg_ring_if;
	logic               valid;
	logic               ready;
	logic signed [31:0] col0_x;
	logic signed [31:0] col0_y;
	logic signed [31:0] col0_z;
	logic signed [31:0] col2_x;
	logic signed [31:0] col2_y;
	logic signed [31:0] col2_z;
	logic signed [31:0] col3_x;
	logic signed [31:0] col3_y;
	logic signed [31:0] col3_z;
	logic [30:0]        ring_radius;
	logic [15:0]        texture_v;

	modport source (output valid, col0_x, col0_y, col0_z, col2_x, col2_y, col2_z,
		col3_x, col3_y, col3_z, ring_radius, texture_v, input ready);
	modport sink (input valid, col0_x, col0_y, col0_z, col2_x, col2_y, col2_z,
		col3_x, col3_y, col3_z, ring_radius, texture_v, output ready);
endinterface

interface trvg_vertex_if;
	logic               valid;
	logic               ready;
	logic signed [31:0] pos_x;
	logic signed [31:0] pos_y;
	logic signed [31:0] pos_z;
	logic signed [15:0] normal_x;
	logic signed [15:0] normal_y;
	logic signed [15:0] normal_z;
	logic [15:0]        tex_u;
	logic [15:0]        tex_v;
	logic               last_in_ring;

	modport source (output valid, pos_x, pos_y, pos_z, normal_x, normal_y, normal_z,
		tex_u, tex_v, last_in_ring, input ready);
	modport sink (input valid, pos_x, pos_y, pos_z, normal_x, normal_y, normal_z,
		tex_u, tex_v, last_in_ring, output ready);
endinterface

// ===== design/trvg_seq.sv =====
// Ring sequencer: density register, reciprocal divider and per-vertex phase stepping.
module trvg_seq #(
	parameter int MAX_RING_VERTICES = 64
) (
	input  logic                clk,
	input  logic                arst_n,
	trvg_ring_if.sink           rings,
	input  logic                cfg_wr_en,
	input  logic [6:0]          cfg_wr_data,
	input  logic                en,
	output logic                c_vld,
	output trvg_pkg::cordic_t   c_out,
	output trvg_pkg::seq_stat_t stat
);
	import trvg_pkg::*;

	localparam int SW = $clog2(MAX_RING_VERTICES);
	localparam logic [8:0] DMAX = 9'(MAX_RING_VERTICES);
	localparam logic [5:0] STEP_Q15  = 6'd15;
	localparam logic [5:0] STEP_LAST = 6'd32;

	logic [6:0]    density_q;
	logic          div_busy_q;
	logic [5:0]    div_step_q;
	logic [SW-1:0] drem_q;
	logic [31:0]   dq_q;
	logic [31:0]   q32_q;
	logic [SW-1:0] r32_q;
	logic [15:0]   q15_q;
	logic [SW-1:0] r15_q;

	logic          active_q;
	logic [SW-1:0] k_q;
	logic [31:0]   ph_q;
	logic [SW-1:0] phr_q;
	logic [15:0]   tu_q;
	logic [SW-1:0] tur_q;
	ring_t         ring_q;

	logic [8:0]    d9;
	logic [SW-1:0] span;
	logic [SW-1:0] half;
	logic [SW:0]   rem2;
	logic          dge;
	logic [SW-1:0] drem_n;
	logic [31:0]   dq_n;
	logic [SW:0]   phs, tus;
	logic          pge, tge;
	logic [SW-1:0] phr_n, tur_n;
	logic          last_now;
	logic          accept;
	logic [31:0]   pf;

	// density clamp and span
	always_comb begin
		d9 = {2'b00, density_q};
		if (d9 < 9'd3) d9 = 9'd3;
		if (d9 > DMAX) d9 = DMAX;
	end
	assign span = SW'(d9 - 9'd1);
	assign half = span >> 1;

	// one restoring step of 2^32 / span
	assign rem2   = {drem_q, (div_step_q == 6'd0)};
	assign dge    = rem2 >= {1'b0, span};
	assign drem_n = SW'(dge ? rem2 - {1'b0, span} : rem2);
	assign dq_n   = {dq_q[30:0], dge};

	// phase and texture u stepping by quotient plus remainder carry
	assign phs   = {1'b0, phr_q} + {1'b0, r32_q};
	assign pge   = phs >= {1'b0, span};
	assign phr_n = SW'(pge ? phs - {1'b0, span} : phs);
	assign tus   = {1'b0, tur_q} + {1'b0, r15_q};
	assign tge   = tus >= {1'b0, span};
	assign tur_n = SW'(tge ? tus - {1'b0, span} : tus);

	assign last_now    = k_q == span;
	assign rings.ready = !div_busy_q && (!active_q || (last_now && en));
	assign accept      = rings.valid && rings.ready;

	// control and divider state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			density_q  <= 7'd16;
			div_busy_q <= 1'b1;
			div_step_q <= '0;
			drem_q     <= '0;
			dq_q       <= '0;
			q32_q      <= '0;
			r32_q      <= '0;
			q15_q      <= '0;
			r15_q      <= '0;
			active_q   <= 1'b0;
			k_q        <= '0;
			ph_q       <= '0;
			phr_q      <= '0;
			tu_q       <= '0;
			tur_q      <= '0;
		end else begin
			if (cfg_wr_en) begin
				density_q  <= cfg_wr_data;
				div_busy_q <= 1'b1;
				div_step_q <= '0;
				drem_q     <= '0;
				dq_q       <= '0;
			end else if (div_busy_q) begin
				drem_q     <= drem_n;
				dq_q       <= dq_n;
				div_step_q <= div_step_q + 6'd1;
				if (div_step_q == STEP_Q15) begin
					q15_q <= dq_n[15:0];
					r15_q <= drem_n;
				end
				if (div_step_q == STEP_LAST) begin
					q32_q      <= dq_n;
					r32_q      <= drem_n;
					div_busy_q <= 1'b0;
				end
			end
			if (accept) begin
				active_q <= 1'b1;
				k_q      <= '0;
				ph_q     <= '0;
				phr_q    <= half;
				tu_q     <= '0;
				tur_q    <= half;
			end else if (active_q && en) begin
				if (last_now) begin
					active_q <= 1'b0;
				end else begin
					k_q   <= k_q + SW'(1);
					ph_q  <= ph_q + q32_q + 32'(pge);
					phr_q <= phr_n;
					tu_q  <= tu_q + q15_q + 16'(tge);
					tur_q <= tur_n;
				end
			end
		end
	end

	// ring payload capture
	always_ff @(posedge clk) begin
		if (accept) begin
			ring_q.m0     <= {rings.col0_z, rings.col0_y, rings.col0_x};
			ring_q.m2     <= {rings.col2_z, rings.col2_y, rings.col2_x};
			ring_q.m3     <= {rings.col3_z, rings.col3_y, rings.col3_x};
			ring_q.radius <= rings.ring_radius;
			ring_q.tex_v  <= rings.texture_v;
		end
	end

	// quadrant fold into the CORDIC range
	always_comb begin
		c_out.neg  = (ph_q[31:30] == 2'd1) || (ph_q[31:30] == 2'd2);
		pf         = c_out.neg ? ph_q + 32'h8000_0000 : ph_q;
		c_out.x    = CORDIC_GAIN;
		c_out.y    = '0;
		c_out.z    = 34'($signed(pf));
		c_out.info.ring  = ring_q;
		c_out.info.tex_u = tu_q;
		c_out.info.last  = last_now;
	end

	assign c_vld         = active_q;
	assign stat.div_busy = div_busy_q;
	assign stat.active   = active_q;
endmodule

// ===== design/trvg_cordic_cell.sv =====
// One rotation step of the sine/cosine CORDIC chain.
module trvg_cordic_cell #(
	parameter int STEP = 0
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              en,
	input  logic              in_vld,
	input  trvg_pkg::cordic_t in_d,
	output logic              out_vld,
	output trvg_pkg::cordic_t out_d
);
	import trvg_pkg::*;

	localparam logic signed [33:0] AT = 34'(ATAN_TURNS[STEP]);

	cordic_t            nx;
	logic signed [33:0] xs, ys;

	// rotate toward zero residual angle
	always_comb begin
		nx = in_d;
		xs = in_d.x >>> STEP;
		ys = in_d.y >>> STEP;
		if (in_d.z >= 0) begin
			nx.x = in_d.x - ys;
			nx.y = in_d.y + xs;
			nx.z = in_d.z - AT;
		end else begin
			nx.x = in_d.x + ys;
			nx.y = in_d.y - xs;
			nx.z = in_d.z + AT;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) out_vld <= 1'b0;
		else if (en) out_vld <= in_vld;
	end

	always_ff @(posedge clk) begin
		if (en) out_d <= nx;
	end
endmodule

// ===== design/trvg_sqrt_cell.sv =====
// One bit-pair step of the integer square root chain.
module trvg_sqrt_cell #(
	parameter int STEP = 0
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            en,
	input  logic            in_vld,
	input  trvg_pkg::sqrt_t in_d,
	output logic            out_vld,
	output trvg_pkg::sqrt_t out_d
);
	import trvg_pkg::*;

	localparam int SH = 2 * (SQRT_STEPS - 1 - STEP);
	localparam logic [63:0] BIT = 64'd1 << SH;

	sqrt_t       nx;
	logic [63:0] trial;

	// trial subtract of res + bit
	always_comb begin
		nx    = in_d;
		trial = in_d.res + BIT;
		if (in_d.v >= trial) begin
			nx.v   = in_d.v - trial;
			nx.res = (in_d.res >> 1) + BIT;
		end else begin
			nx.res = in_d.res >> 1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) out_vld <= 1'b0;
		else if (en) out_vld <= in_vld;
	end

	always_ff @(posedge clk) begin
		if (en) out_d <= nx;
	end
endmodule

// ===== design/trvg_div_cell.sv =====
// One quotient bit of the three-lane normal divider chain.
module trvg_div_cell #(
	parameter int STEP = 0
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           en,
	input  logic           in_vld,
	input  trvg_pkg::dvd_t in_d,
	output logic           out_vld,
	output trvg_pkg::dvd_t out_d
);
	import trvg_pkg::*;

	localparam int SH = DIV_STEPS - 1 - STEP;

	dvd_t        nx;
	logic [45:0] dd;

	// compare and subtract the shifted divisor in every lane
	always_comb begin
		nx = in_d;
		dd = 46'(in_d.len) << SH;
		for (int i = 0; i < 3; i++) begin
			if (in_d.rem[i] >= dd) begin
				nx.rem[i]   = in_d.rem[i] - dd;
				nx.q[i][SH] = 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) out_vld <= 1'b0;
		else if (en) out_vld <= in_vld;
	end

	always_ff @(posedge clk) begin
		if (en) out_d <= nx;
	end
endmodule

// ===== design/tube_ring_vertex_generator.sv =====
// Throughput: one vertex per cycle while output back-pressure does not stall the pipeline;
// each ring gives ring_density vertices (16 after reset, clamped to 3..MAX_RING_VERTICES);
// the pipeline is 24 CORDIC cells, 12 arithmetic and register stages, 32 root cells and
// 15 divider cells, all stalled together by output back-pressure.
// After reset and after every density write the reciprocal divider runs, and no ring is
// taken while it runs. Reset is asynchronous, active low, and clears all valids.
module tube_ring_vertex_generator #(
	parameter int MAX_RING_VERTICES = 64
) (
	input  logic          clk,
	input  logic          arst_n,
	trvg_ring_if.sink     rings,
	trvg_vertex_if.source vertices,
	input  logic          cfg_wr_en,
	input  logic [6:0]    cfg_wr_data
);
	import trvg_pkg::*;

	typedef struct packed {
		logic [2:0][62:0] mag;
		logic [62:0]      mx;
	} nrm_t;

	logic      en;
	seq_stat_t stat;

	cordic_t cd [CORDIC_STEPS+1];
	logic    cv [CORDIC_STEPS+1];
	sqrt_t   sq [SQRT_STEPS+1];
	logic    sv [SQRT_STEPS+1];
	dvd_t    dv [DIV_STEPS+1];
	logic    dvv [DIV_STEPS+1];

	logic               vld_s1, vld_s2, vld_s3, vld_s4, vld_s5, vld_s6;
	logic               vld_s7, vld_s8, vld_s9, vld_s10, vld_s11, vld_s12;
	vinfo_t             info_s1, info_s2, info_s3, info_s4;
	logic signed [31:0] c_s1, s_s1;
	logic signed [63:0] rc_s2, rs_s2;
	logic signed [63:0] nc_s2 [3];
	logic signed [63:0] ns_s2 [3];
	logic signed [31:0] px_s3, pz_s3;
	logic signed [63:0] n_s3 [3];
	logic signed [63:0] mp_s4 [3];
	logic signed [63:0] mz_s4 [3];
	logic [62:0]        nabs_s4 [3];
	logic [2:0]         nneg_s4;
	tail_t              tail_s5, tail_s6, tail_s7, tail_s8, tail_s9, tail_s10;
	nrm_t               nrm_s5, nrm_s6, nrm_s7, nrm_s8;
	logic [59:0]        sqr_s9 [3];
	dvd_t               num_s11;
	logic [2:0][31:0]   pos_s12;
	logic [2:0][15:0]   nrm_s12;
	logic [15:0]        texu_s12, texv_s12;
	logic               last_s12;

	tail_t              t5;
	tail_t              t9;
	nrm_t               n5;
	logic signed [63:0] acc, rsh, p;
	logic [31:0]        len11;

	// saturate CORDIC output and undo the quadrant fold
	function automatic logic signed [31:0] fold_trig(input logic signed [33:0] v,
		input logic ng);
		logic signed [33:0] t;
		t = v;
		if (v > ONE_Q30) t = ONE_Q30;
		if (v < -ONE_Q30) t = -ONE_Q30;
		if (ng) t = -t;
		return 32'(t);
	endfunction

	// shift all magnitudes left when the top bits of the maximum are clear
	function automatic nrm_t nrm_shift(input nrm_t a, input int sh);
		nrm_t b;
		b = a;
		if ((a.mx >> (63 - sh)) == 63'd0) begin
			b.mx = a.mx << sh;
			for (int i = 0; i < 3; i++) b.mag[i] = a.mag[i] << sh;
		end
		return b;
	endfunction

	assign en = !vld_s12 || vertices.ready;

	trvg_seq #(.MAX_RING_VERTICES(MAX_RING_VERTICES)) u_seq (
		.clk(clk), .arst_n(arst_n), .rings(rings), .cfg_wr_en(cfg_wr_en),
		.cfg_wr_data(cfg_wr_data), .en(en), .c_vld(cv[0]), .c_out(cd[0]), .stat(stat)
	);

	// CORDIC chain
	for (genvar g = 0; g < CORDIC_STEPS; g++) begin : g_cordic
		trvg_cordic_cell #(.STEP(g)) u_cell (
			.clk(clk), .arst_n(arst_n), .en(en), .in_vld(cv[g]), .in_d(cd[g]),
			.out_vld(cv[g+1]), .out_d(cd[g+1])
		);
	end

	// position stage 5 combinational: round, translate, saturate; normal magnitude max
	always_comb begin
		t5    = '0;
		n5    = '0;
		acc   = '0;
		rsh   = '0;
		p     = '0;
		for (int i = 0; i < 3; i++) begin
			acc = mp_s4[i] + mz_s4[i];
			rsh = (acc + 64'sd32768) >>> 16;
			p   = rsh + 64'($signed(info_s4.ring.m3[i]));
			if (p > 64'sd2147483647) t5.pos[i] = 32'h7FFF_FFFF;
			else if (p < -64'sd2147483648) t5.pos[i] = 32'h8000_0000;
			else t5.pos[i] = p[31:0];
			n5.mag[i] = nabs_s4[i];
			if (nabs_s4[i] > n5.mx) n5.mx = nabs_s4[i];
		end
		t5.nneg  = nneg_s4;
		t5.nzero = (info_s4.ring.radius == 31'd0) || (n5.mx == 63'd0);
		t5.tex_u = info_s4.tex_u;
		t5.tex_v = info_s4.ring.tex_v;
		t5.last  = info_s4.last;
	end

	// stage 9 tail: keep the top 30 bits of each normalized magnitude
	always_comb begin
		t9 = tail_s8;
		for (int i = 0; i < 3; i++) t9.nmag[i] = nrm_s8.mag[i][62:33];
	end

	// arithmetic stage valids
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0; vld_s2 <= 1'b0; vld_s3 <= 1'b0; vld_s4 <= 1'b0;
			vld_s5 <= 1'b0; vld_s6 <= 1'b0; vld_s7 <= 1'b0; vld_s8 <= 1'b0;
			vld_s9 <= 1'b0; vld_s10 <= 1'b0; vld_s11 <= 1'b0; vld_s12 <= 1'b0;
		end else if (en) begin
			vld_s1  <= cv[CORDIC_STEPS];
			vld_s2  <= vld_s1;
			vld_s3  <= vld_s2;
			vld_s4  <= vld_s3;
			vld_s5  <= vld_s4;
			vld_s6  <= vld_s5;
			vld_s7  <= vld_s6;
			vld_s8  <= vld_s7;
			vld_s9  <= vld_s8;
			vld_s10 <= vld_s9;
			vld_s11 <= sv[SQRT_STEPS];
			vld_s12 <= dvv[DIV_STEPS];
		end
	end

	// trig, products, point, transform, normalize and square stages
	always_ff @(posedge clk) begin
		if (en) begin
			c_s1    <= fold_trig(cd[CORDIC_STEPS].x, cd[CORDIC_STEPS].neg);
			s_s1    <= fold_trig(cd[CORDIC_STEPS].y, cd[CORDIC_STEPS].neg);
			info_s1 <= cd[CORDIC_STEPS].info;

			rc_s2   <= $signed({1'b0, info_s1.ring.radius}) * c_s1;
			rs_s2   <= $signed({1'b0, info_s1.ring.radius}) * s_s1;
			for (int i = 0; i < 3; i++) begin
				nc_s2[i] <= $signed(info_s1.ring.m0[i]) * c_s1;
				ns_s2[i] <= $signed(info_s1.ring.m2[i]) * s_s1;
			end
			info_s2 <= info_s1;

			px_s3 <= 32'((rc_s2 + 64'sd1073741824) >>> 31);
			pz_s3 <= 32'((rs_s2 + 64'sd1073741824) >>> 31);
			for (int i = 0; i < 3; i++) n_s3[i] <= nc_s2[i] + ns_s2[i];
			info_s3 <= info_s2;

			for (int i = 0; i < 3; i++) begin
				mp_s4[i]   <= $signed(info_s3.ring.m0[i]) * px_s3;
				mz_s4[i]   <= $signed(info_s3.ring.m2[i]) * pz_s3;
				nabs_s4[i] <= 63'(n_s3[i] < 0 ? -n_s3[i] : n_s3[i]);
				nneg_s4[i] <= n_s3[i] < 0;
			end
			info_s4 <= info_s3;

			tail_s5 <= t5;
			nrm_s5  <= n5;

			nrm_s6  <= nrm_shift(nrm_shift(nrm_s5, 32), 16);
			tail_s6 <= tail_s5;
			nrm_s7  <= nrm_shift(nrm_shift(nrm_s6, 8), 4);
			tail_s7 <= tail_s6;
			nrm_s8  <= nrm_shift(nrm_shift(nrm_s7, 2), 1);
			tail_s8 <= tail_s7;

			tail_s9 <= t9;
			for (int i = 0; i < 3; i++) begin
				sqr_s9[i] <= nrm_s8.mag[i][62:33] * nrm_s8.mag[i][62:33];
			end

			tail_s10 <= tail_s9;
		end
	end

	// sum of squares feeds the root chain
	logic [63:0] v_s10;
	always_ff @(posedge clk) begin
		if (en) v_s10 <= 64'(sqr_s9[0]) + 64'(sqr_s9[1]) + 64'(sqr_s9[2]);
	end

	assign sq[0].v    = v_s10;
	assign sq[0].res  = '0;
	assign sq[0].tail = tail_s10;
	assign sv[0]      = vld_s10;

	for (genvar g = 0; g < SQRT_STEPS; g++) begin : g_sqrt
		trvg_sqrt_cell #(.STEP(g)) u_cell (
			.clk(clk), .arst_n(arst_n), .en(en), .in_vld(sv[g]), .in_d(sq[g]),
			.out_vld(sv[g+1]), .out_d(sq[g+1])
		);
	end

	// divider numerators: magnitude times 2^14 plus half the length
	assign len11 = sq[SQRT_STEPS].res[31:0];
	always_ff @(posedge clk) begin
		if (en) begin
			num_s11.len  <= len11;
			num_s11.q    <= '0;
			num_s11.tail <= sq[SQRT_STEPS].tail;
			for (int i = 0; i < 3; i++)
				num_s11.rem[i] <= {2'b00, sq[SQRT_STEPS].tail.nmag[i], 14'd0}
					+ 46'(len11 >> 1);
		end
	end

	assign dv[0]  = num_s11;
	assign dvv[0] = vld_s11;

	for (genvar g = 0; g < DIV_STEPS; g++) begin : g_div
		trvg_div_cell #(.STEP(g)) u_cell (
			.clk(clk), .arst_n(arst_n), .en(en), .in_vld(dvv[g]), .in_d(dv[g]),
			.out_vld(dvv[g+1]), .out_d(dv[g+1])
		);
	end

	// output register: sign and zero handling of the normal
	always_ff @(posedge clk) begin
		if (en) begin
			pos_s12  <= dv[DIV_STEPS].tail.pos;
			texu_s12 <= dv[DIV_STEPS].tail.tex_u;
			texv_s12 <= dv[DIV_STEPS].tail.tex_v;
			last_s12 <= dv[DIV_STEPS].tail.last;
			for (int i = 0; i < 3; i++) begin
				if (dv[DIV_STEPS].tail.nzero) nrm_s12[i] <= '0;
				else if (dv[DIV_STEPS].tail.nneg[i]) nrm_s12[i] <= -16'(dv[DIV_STEPS].q[i]);
				else nrm_s12[i] <= 16'(dv[DIV_STEPS].q[i]);
			end
		end
	end

	assign vertices.valid        = vld_s12;
	assign vertices.pos_x        = pos_s12[0];
	assign vertices.pos_y        = pos_s12[1];
	assign vertices.pos_z        = pos_s12[2];
	assign vertices.normal_x     = nrm_s12[0];
	assign vertices.normal_y     = nrm_s12[1];
	assign vertices.normal_z     = nrm_s12[2];
	assign vertices.tex_u        = texu_s12;
	assign vertices.tex_v        = texv_s12;
	assign vertices.last_in_ring = last_s12;

`ifndef SYNTHESIS
	a_accept_starts: assert property (@(posedge clk) disable iff (!arst_n)
		rings.valid && rings.ready |=> stat.active)
		else $error("accepted ring did not start the sequencer");
	a_busy_blocks: assert property (@(posedge clk) disable iff (!arst_n)
		stat.div_busy |-> !rings.ready)
		else $error("ring taken while reciprocal divider runs");
	a_seam_u: assert property (@(posedge clk) disable iff (!arst_n)
		vertices.valid && vertices.last_in_ring |-> vertices.tex_u == 16'd32768)
		else $error("last vertex of ring without full texture u");
	a_unit_normal: assert property (@(posedge clk) disable iff (!arst_n)
		vertices.valid |-> vertices.normal_x <= 16'sd16384 && vertices.normal_x >= -16'sd16384)
		else $error("normal component out of unit range");
`endif
endmodule
